>>> rtl/ircr_pkg.sv
package ircr_pkg;

    localparam int FREQ_W = 19;
    localparam int NUM_W  = 25;

    localparam logic [16:0] K_PULSE = 17'd78000;
    localparam logic [16:0] K_SPACE = 17'd80000;
    localparam logic [NUM_W-1:0] RAW_HDR_NUM    = 25'd2500000;
    localparam logic [NUM_W-1:0] PRONTO_HDR_NUM = 25'd4145146;

    // f / 100 as (f * ceil(2^26 / 100)) >> 26, exact for any 19-bit f
    localparam logic [19:0] TRAILER_RECIP = 20'd671089;
    localparam int          TRAILER_SHIFT = 26;

    localparam logic [7:0] BYTE_END     = 8'hff;
    localparam logic [7:0] BYTE_PARTIAL = 8'h80;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_GAP   = 2'd1;
    localparam logic [1:0] PH_PULSE = 2'd2;
    localparam logic [1:0] PH_SPACE = 2'd3;

    localparam logic [1:0] ST_CAPTURING = 2'd0;
    localparam logic [1:0] ST_COMPLETE  = 2'd1;
    localparam logic [1:0] ST_PARTIAL   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [1:0] REG_FREQ   = 2'd0;
    localparam logic [1:0] REG_REPEAT = 2'd1;
    localparam logic [1:0] REG_FORMAT = 2'd2;
    localparam logic [1:0] REG_OPCODE = 2'd3;

    localparam logic FUNC_FEED  = 1'b0;
    localparam logic FMT_PRONTO = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic [1:0] capture_status;
        logic [8:0] edge_count;
    } t_out;

endpackage

>>> rtl/ircr_div.sv
module ircr_div
    import ircr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [FREQ_W-1:0] i_den,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [FREQ_W-1:0] r_den;
    logic [FREQ_W-1:0] r_rem;
    logic [FREQ_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                // one quotient bit per cycle, shifted into the dividend register
                r_rem <= fits ? FREQ_W'(trial - {1'b0, r_den}) : trial[FREQ_W-1:0];
                r_num <= {r_num[NUM_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

>>> rtl/ircr_capture.sv
module ircr_capture
    import ircr_pkg::*;
#(
    parameter int MAX_PAIRS = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_feed,
    input  logic [7:0]                     i_byte,
    input  logic                           i_rd_space,
    input  logic [$clog2(MAX_PAIRS)-1:0]   i_rd_idx,
    output logic [7:0]                     o_rd_data,
    output logic [1:0]                     o_status,
    output logic [15:0]                    o_gap,
    output logic [$clog2(MAX_PAIRS+1)-1:0] o_pulse_total,
    output logic [$clog2(MAX_PAIRS+1)-1:0] o_space_total
);
    localparam int IW = $clog2(MAX_PAIRS);
    localparam int CW = $clog2(MAX_PAIRS + 1);

    logic [7:0] pulse_mem [MAX_PAIRS];
    logic [7:0] space_mem [MAX_PAIRS];

    logic [1:0]    r_phase, n_phase;
    logic          r_half, n_half;
    logic [15:0]   r_gap, n_gap;
    logic [CW-1:0] r_pt, n_pt;
    logic [CW-1:0] r_st, n_st;
    logic [1:0]    r_status, n_status;
    logic          wr_pulse, wr_space;

    always_comb begin
        logic [1:0] ph;
        ph       = r_phase;
        n_phase  = r_phase;
        n_half   = r_half;
        n_gap    = r_gap;
        n_pt     = r_pt;
        n_st     = r_st;
        n_status = r_status;
        wr_pulse = 1'b0;
        wr_space = 1'b0;
        if (i_feed) begin
            if (ph == PH_IDLE) begin
                n_pt     = '0;
                n_st     = '0;
                n_status = ST_CAPTURING;
                ph       = PH_GAP;
            end
            unique case (ph)
                PH_GAP: begin
                    if (!r_half || r_phase == PH_IDLE) begin
                        n_gap   = {i_byte, 8'h00};
                        n_half  = 1'b1;
                        n_phase = PH_GAP;
                    end else begin
                        n_gap   = {r_gap[15:8], i_byte};
                        n_half  = 1'b0;
                        n_phase = PH_PULSE;
                    end
                end
                PH_PULSE: begin
                    if (r_pt < CW'(MAX_PAIRS)) begin
                        wr_pulse = 1'b1;
                        n_pt     = r_pt + 1'b1;
                    end else begin
                        n_status = ST_OVERFLOW;
                    end
                    n_phase = PH_SPACE;
                end
                PH_SPACE: begin
                    if (i_byte == BYTE_END || i_byte > BYTE_PARTIAL) begin
                        if (r_status != ST_OVERFLOW)
                            n_status = (i_byte == BYTE_END) ? ST_COMPLETE : ST_PARTIAL;
                        n_phase = PH_IDLE;
                    end else begin
                        if (r_st < CW'(MAX_PAIRS)) begin
                            wr_space = 1'b1;
                            n_st     = r_st + 1'b1;
                        end else begin
                            n_status = ST_OVERFLOW;
                        end
                        n_phase = PH_PULSE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_half   <= 1'b0;
            r_gap    <= '0;
            r_pt     <= '0;
            r_st     <= '0;
            r_status <= ST_CAPTURING;
        end else begin
            r_phase  <= n_phase;
            r_half   <= n_half;
            r_gap    <= n_gap;
            r_pt     <= n_pt;
            r_st     <= n_st;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_pulse)
            pulse_mem[r_pt[IW-1:0]] <= i_byte;
        if (wr_space)
            space_mem[r_st[IW-1:0]] <= i_byte;
        o_rd_data <= i_rd_space ? space_mem[i_rd_idx] : pulse_mem[i_rd_idx];
    end

    assign o_status      = r_status;
    assign o_gap         = r_gap;
    assign o_pulse_total = r_pt;
    assign o_space_total = r_st;
endmodule

>>> rtl/ir_raw_capture_reencoder.sv
// IR capture re-encoder. A feed item (func 0) stores one capture byte and
// returns its result from the S_FDONE state after acceptance. A fetch item (func 1)
// rebuilds the formatted command from the stored tables on every call: one
// header division, then for each stored edge a table read, a multiply and a
// 25-step serial division, plus a reciprocal multiply for the trailer in
// pronto mode. busy stays high until the result is issued: o_valid rises in
// the same cycle that busy falls. The single serial divider is shared by
// the header and edge divisions. busy is high while an item is at work;
// each result appears on o_res for one cycle with o_valid and must be taken
// then, as the receiver cannot stall the block.
module ir_raw_capture_reencoder
    import ircr_pkg::*;
#(
    parameter int MAX_PAIRS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  t_in               i_in,
    output logic              busy,
    output logic              o_valid,
    output t_out              o_res,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [FREQ_W-1:0] i_cfg_data
);
    localparam int IW = $clog2(MAX_PAIRS);
    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int EW = CW + 1;
    localparam int PW = $clog2(10 + 4 * MAX_PAIRS + 1);
    localparam int TRP_W = FREQ_W + 20;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FDONE = 4'd1;
    localparam logic [3:0] S_HDIV  = 4'd2;
    localparam logic [3:0] S_HWAIT = 4'd3;
    localparam logic [3:0] S_ERD   = 4'd4;
    localparam logic [3:0] S_EMUL  = 4'd5;
    localparam logic [3:0] S_EDIV  = 4'd6;
    localparam logic [3:0] S_EWAIT = 4'd7;
    localparam logic [3:0] S_TDIV  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [FREQ_W-1:0] r_freq;
    logic [7:0]        r_repeat;
    logic              r_format;
    logic [7:0]        r_opcode;

    logic [3:0]       r_state;
    logic             r_valid;
    t_out             r_res;
    logic [PW-1:0]    r_ptr;
    logic [PW-1:0]    r_pos;
    logic [EW-1:0]    r_j;
    logic [EW-1:0]    r_esc;
    logic [NUM_W-1:0] r_prod;
    logic [NUM_W-1:0] r_hv;
    logic [15:0]      r_tr;
    logic [7:0]       r_hit;

    logic              accept, feed;
    logic [FREQ_W-1:0] feff;
    logic [7:0]        rd_data;
    logic [1:0]        cap_status;
    logic [15:0]       gap;
    logic [CW-1:0]     pt, st;
    logic [EW-1:0]     edges;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quo;
    logic [FREQ_W-1:0] div_den;
    logic              is_pronto;
    logic [TRP_W-1:0]  tr_prod;

    assign accept    = start && !busy;
    assign feed      = accept && (i_in.func == FUNC_FEED);
    assign feff      = (r_freq == '0) ? FREQ_W'(1) : r_freq;
    assign edges     = EW'(pt) + EW'(st);
    assign is_pronto = (r_format == FMT_PRONTO);
    assign busy      = (r_state != S_IDLE);
    assign tr_prod   = TRP_W'(feff) * TRP_W'(TRAILER_RECIP);

    ircr_capture #(.MAX_PAIRS(MAX_PAIRS)) u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_feed        (feed),
        .i_byte        (i_in.data_byte),
        .i_rd_space    (r_j[0]),
        .i_rd_idx      (r_j[IW:1]),
        .o_rd_data     (rd_data),
        .o_status      (cap_status),
        .o_gap         (gap),
        .o_pulse_total (pt),
        .o_space_total (st)
    );

    assign div_start = (r_state == S_HDIV) || (r_state == S_EDIV);
    assign div_den   = feff;
    always_comb begin
        div_num = r_prod;
        if (r_state == S_HDIV)
            div_num = is_pronto ? PRONTO_HDR_NUM : RAW_HDR_NUM;
    end

    ircr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // scaled duration, saturated per format
    logic [15:0]   tsat;
    logic          two_bytes;
    logic [PW-1:0] pos_next;
    always_comb begin
        if (is_pronto)
            tsat = (div_quo > NUM_W'(16'hffff)) ? 16'hffff : div_quo[15:0];
        else
            tsat = (div_quo > NUM_W'(16'h7fff)) ? 16'h7fff : div_quo[15:0];
        two_bytes = is_pronto || (tsat >= 16'h0080);
        pos_next  = r_pos + (two_bytes ? PW'(2) : PW'(1));
    end

    // final byte selection
    logic [PW-1:0] len, eff, hdr_len;
    logic [7:0]    fin_byte;
    logic [7:0]    xe;
    logic [15:0]   hv_word;
    always_comb begin
        len      = is_pronto ? r_pos + PW'(2) : r_pos;
        hdr_len  = is_pronto ? PW'(8) : PW'(7);
        eff      = (r_ptr >= len) ? '0 : r_ptr;
        xe       = 8'(edges + r_esc);
        hv_word  = (r_hv > NUM_W'(16'hffff)) ? 16'hffff : r_hv[15:0];
        fin_byte = r_hit;
        if (eff < hdr_len) begin
            if (is_pronto) begin
                case (eff[2:0])
                    3'd2:    fin_byte = hv_word[15:8];
                    3'd3:    fin_byte = hv_word[7:0];
                    3'd6:    fin_byte = 8'(pt >> 8);
                    3'd7:    fin_byte = 8'(pt);
                    default: fin_byte = 8'h00;
                endcase
            end else begin
                case (eff[2:0])
                    3'd0:    fin_byte = r_opcode;
                    3'd1:    fin_byte = xe + 8'd6;
                    3'd2:    fin_byte = (r_hv > NUM_W'(8'hff)) ? 8'hff : r_hv[7:0];
                    3'd3:    fin_byte = r_repeat;
                    3'd4:    fin_byte = gap[15:8];
                    3'd5:    fin_byte = gap[7:0];
                    default: fin_byte = xe;
                endcase
            end
        end else if (is_pronto && eff >= r_pos) begin
            fin_byte = (eff == r_pos) ? r_tr[15:8] : r_tr[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq   <= 19'd38461;
            r_repeat <= 8'd1;
            r_format <= 1'b0;
            r_opcode <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FREQ:   r_freq   <= i_cfg_data;
                REG_REPEAT: r_repeat <= i_cfg_data[7:0];
                REG_FORMAT: r_format <= i_cfg_data[0];
                REG_OPCODE: r_opcode <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_ptr   <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (feed) begin
                            r_ptr   <= '0;
                            r_state <= S_FDONE;
                        end else begin
                            r_state <= S_HDIV;
                        end
                    end
                end
                S_FDONE: begin
                    r_res   <= '{8'h00, 1'b0, cap_status, 9'(edges)};
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_HDIV: r_state <= S_HWAIT;
                S_HWAIT: begin
                    if (div_done) begin
                        r_hv    <= div_quo;
                        r_pos   <= is_pronto ? PW'(8) : PW'(7);
                        r_j     <= '0;
                        r_esc   <= '0;
                        r_hit   <= '0;
                        r_state <= S_ERD;
                    end
                end
                S_ERD: begin
                    // table read address follows r_j; data lands next cycle
                    if (r_j == edges)
                        r_state <= is_pronto ? S_TDIV : S_FIN;
                    else
                        r_state <= S_EMUL;
                end
                S_EMUL: begin
                    r_prod  <= NUM_W'((r_j[0] && !is_pronto) ? K_SPACE : K_PULSE)
                               * NUM_W'(rd_data);
                    r_state <= S_EDIV;
                end
                S_EDIV: r_state <= S_EWAIT;
                S_EWAIT: begin
                    if (div_done) begin
                        if (r_ptr == r_pos) begin
                            if (!two_bytes)
                                r_hit <= tsat[7:0];
                            else if (is_pronto)
                                r_hit <= tsat[15:8];
                            else
                                r_hit <= {1'b1, tsat[14:8]};
                        end else if (two_bytes && r_ptr == r_pos + PW'(1)) begin
                            r_hit <= tsat[7:0];
                        end
                        if (!is_pronto && two_bytes)
                            r_esc <= r_esc + 1'b1;
                        r_pos   <= pos_next;
                        r_j     <= r_j + 1'b1;
                        r_state <= S_ERD;
                    end
                end
                S_TDIV: begin
                    r_tr    <= 16'(tr_prod >> TRAILER_SHIFT);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res   <= '{fin_byte, (eff + PW'(1) == len), cap_status, 9'(edges)};
                    r_ptr   <= (eff + PW'(1) == len) ? '0 : eff + PW'(1);
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

>>> test/testbench.sv
module testbench;
    import ircr_pkg::*;

    localparam int  MAX_PAIRS  = 128;
    localparam int  CMD_MAX    = 10 + 4 * MAX_PAIRS;
    localparam int  LIMIT      = 4000000;
    localparam int  ITEM_GOAL  = 1400;
    localparam logic FUNC_FETCH = 1'b1;
    localparam logic FMT_RAW    = 1'b0;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    t_in               i_in = '0;
    logic              busy;
    logic              o_valid;
    t_out              o_res;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_idx = REG_FREQ;
    logic [FREQ_W-1:0] i_cfg_data = '0;

    ir_raw_capture_reencoder #(.MAX_PAIRS(MAX_PAIRS)) dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [FREQ_W-1:0] cfg_freq = 19'd38461;
    logic [7:0]        cfg_repeat = 8'd1;
    logic              cfg_format = FMT_RAW;
    logic [7:0]        cfg_opcode = 8'd0;
    logic [1:0]        cap_phase = PH_IDLE;
    logic              gap_half = 1'b0;
    logic [15:0]       gap_word = '0;
    logic [7:0]        pulse_tab [MAX_PAIRS];
    logic [7:0]        space_tab [MAX_PAIRS];
    int                n_pulses = 0;
    int                n_spaces = 0;
    int                rd_ptr = 0;
    logic [1:0]        cap_state = ST_CAPTURING;
    logic [7:0]        cmd_bytes [CMD_MAX];

    t_out   expected_q[$];
    int     errors = 0;
    int     items_sent = 0;
    longint cycles = 0;

    function automatic longint scaled(longint k, longint x, longint lim);
        longint f, t;
        f = (cfg_freq == 0) ? 1 : cfg_freq;
        t = (k * x) / f;
        return (t > lim) ? lim : t;
    endfunction

    // fill cmd_bytes with the command for the current tables, return its length
    function automatic int build_command();
        int n, esc, edges;
        longint f, v, t;
        f = (cfg_freq == 0) ? 1 : cfg_freq;
        edges = n_pulses + n_spaces;
        n = 0;
        esc = 0;
        if (cfg_format == FMT_PRONTO) begin
            v = 4145146 / f;
            if (v > 16'hffff) v = 16'hffff;
            cmd_bytes[0] = 8'h00; cmd_bytes[1] = 8'h00;
            cmd_bytes[2] = v[15:8]; cmd_bytes[3] = v[7:0];
            cmd_bytes[4] = 8'h00; cmd_bytes[5] = 8'h00;
            cmd_bytes[6] = 8'h00; cmd_bytes[7] = n_pulses[7:0];
            n = 8;
            for (int i = 0; i < n_pulses || i < n_spaces; i++) begin
                if (i < n_pulses) begin
                    t = scaled(78000, pulse_tab[i], 16'hffff);
                    cmd_bytes[n] = t[15:8]; cmd_bytes[n+1] = t[7:0]; n += 2;
                end
                if (i < n_spaces) begin
                    t = scaled(78000, space_tab[i], 16'hffff);
                    cmd_bytes[n] = t[15:8]; cmd_bytes[n+1] = t[7:0]; n += 2;
                end
            end
            t = f / 100;
            cmd_bytes[n] = t[15:8]; cmd_bytes[n+1] = t[7:0];
            return n + 2;
        end
        v = 2500000 / f;
        cmd_bytes[0] = cfg_opcode;
        cmd_bytes[2] = (v > 255) ? 8'hff : v[7:0];
        cmd_bytes[3] = cfg_repeat;
        cmd_bytes[4] = gap_word[15:8];
        cmd_bytes[5] = gap_word[7:0];
        n = 7;
        for (int i = 0; i < n_pulses || i < n_spaces; i++) begin
            for (int s = 0; s < 2; s++) begin
                if (s == 0 && i >= n_pulses) continue;
                if (s == 1 && i >= n_spaces) continue;
                t = (s == 0) ? scaled(78000, pulse_tab[i], 16'h7fff)
                             : scaled(80000, space_tab[i], 16'h7fff);
                if (t >= 128) begin
                    cmd_bytes[n] = 8'h80 | t[14:8];
                    cmd_bytes[n+1] = t[7:0];
                    n += 2;
                    esc++;
                end else begin
                    cmd_bytes[n] = t[7:0];
                    n += 1;
                end
            end
        end
        cmd_bytes[1] = 8'(6 + edges + esc);
        cmd_bytes[6] = 8'(edges + esc);
        return n;
    endfunction

    function automatic void finish_capture(logic [1:0] code);
        if (cap_state != ST_OVERFLOW) cap_state = code;
        cap_phase = PH_IDLE;
    endfunction

    function automatic t_out predict_item(t_in it);
        t_out r;
        int len;
        r = '0;
        if (it.func == FUNC_FEED) begin
            rd_ptr = 0;
            if (cap_phase == PH_IDLE) begin
                n_pulses = 0; n_spaces = 0; gap_word = '0; gap_half = 1'b0;
                cap_state = ST_CAPTURING;
                cap_phase = PH_GAP;
            end
            case (cap_phase)
                PH_GAP: begin
                    if (!gap_half) begin
                        gap_word = {it.data_byte, 8'h00};
                        gap_half = 1'b1;
                    end else begin
                        gap_word[7:0] = it.data_byte;
                        gap_half = 1'b0;
                        cap_phase = PH_PULSE;
                    end
                end
                PH_PULSE: begin
                    if (n_pulses < MAX_PAIRS) pulse_tab[n_pulses++] = it.data_byte;
                    else cap_state = ST_OVERFLOW;
                    cap_phase = PH_SPACE;
                end
                default: begin
                    if (it.data_byte == BYTE_END) finish_capture(ST_COMPLETE);
                    else if (it.data_byte > BYTE_PARTIAL) finish_capture(ST_PARTIAL);
                    else begin
                        if (n_spaces < MAX_PAIRS) space_tab[n_spaces++] = it.data_byte;
                        else cap_state = ST_OVERFLOW;
                        cap_phase = PH_PULSE;
                    end
                end
            endcase
        end else begin
            len = build_command();
            if (rd_ptr >= len) rd_ptr = 0;
            r.out_byte = cmd_bytes[rd_ptr];
            r.last_byte = (rd_ptr + 1 == len);
            rd_ptr = r.last_byte ? 0 : rd_ptr + 1;
        end
        r.capture_status = cap_state;
        r.edge_count = 9'(n_pulses + n_spaces);
        return r;
    endfunction

    // send one item after a gap; start stays high on return
    task automatic send_item(logic func, logic [7:0] data, int gap);
        t_in it;
        it.func = func;
        it.data_byte = data;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (busy);
        expected_q.push_back(predict_item(it));
        items_sent++;
    endtask

    task automatic feed(logic [7:0] b);
        send_item(FUNC_FEED, b, $urandom_range(0, 15));
    endtask

    task automatic fetch();
        send_item(FUNC_FETCH, 8'($urandom), $urandom_range(0, 15));
    endtask

    task automatic drain();
        if (start) start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [FREQ_W-1:0] val);
        drain();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FREQ:   cfg_freq = val;
            REG_REPEAT: cfg_repeat = val[7:0];
            REG_FORMAT: cfg_format = val[0];
            default:    cfg_opcode = val[7:0];
        endcase
    endtask

    task automatic feed_capture(int pairs, logic [7:0] end_b);
        feed(8'($urandom));
        feed(8'($urandom));
        for (int i = 0; i < pairs; i++) begin
            feed(8'($urandom));
            feed(8'($urandom_range(0, 128)));
        end
        feed(8'($urandom));
        feed(end_b);
    endtask

    task automatic test_reset_readout();
        repeat (9) fetch();
    endtask

    task automatic test_directed();
        write_reg(REG_OPCODE, 19'h0ff);
        write_reg(REG_REPEAT, 19'h0ff);
        feed(8'hff); feed(8'hff);
        feed(8'h00); feed(8'h00);
        feed(8'hff); feed(8'h80);   // 0x80 is stored as a space
        feed(8'h01);
        feed(8'h81);                // partial end
        repeat (4) fetch();
        feed(8'h00);                // new capture, readout restarts
        feed(8'h00);
        feed(8'hff); feed(8'hff);   // complete end
        repeat (12) fetch();        // runs past the end and wraps
        write_reg(REG_FORMAT, FMT_PRONTO);
        repeat (14) fetch();
        write_reg(REG_FREQ, 19'd0);
        repeat (3) fetch();
        write_reg(REG_FREQ, 19'd500000);
        repeat (3) fetch();
        write_reg(REG_FORMAT, FMT_RAW);
        write_reg(REG_FREQ, 19'd1);
        repeat (3) fetch();
    endtask

    task automatic test_overflow();
        write_reg(REG_FREQ, 19'd38461);
        feed(8'h12); feed(8'h34);
        for (int i = 0; i < MAX_PAIRS + 2; i++) begin
            feed(8'($urandom));
            feed(8'($urandom_range(0, 128)));
        end
        fetch();
        fetch();
        feed(8'h05);
        feed(8'hff);
        fetch();
    endtask

    task automatic test_random();
        int pairs, len;
        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_reg(REG_FREQ, ($urandom_range(0, 7) == 0)
                                 ? 19'($urandom) : 19'($urandom_range(1, 500000)));
                    1: write_reg(REG_REPEAT, 19'($urandom_range(0, 255)));
                    2: write_reg(REG_FORMAT, 19'($urandom_range(0, 1)));
                    default: write_reg(REG_OPCODE, 19'($urandom_range(0, 255)));
                endcase
            end
            if ($urandom_range(0, 9) == 0) begin
                // noise: arbitrary items
                repeat ($urandom_range(1, 8))
                    send_item(1'($urandom), 8'($urandom), $urandom_range(0, 15));
                continue;
            end
            pairs = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 30)
                                                 : $urandom_range(0, 6);
            feed(8'($urandom));
            feed(8'($urandom));
            for (int i = 0; i < pairs; i++) begin
                feed(8'($urandom));
                if ($urandom_range(0, 5) == 0) fetch();
                feed(8'($urandom_range(0, 128)));
            end
            feed(8'($urandom));
            feed(($urandom_range(0, 1) == 0) ? BYTE_END : 8'($urandom_range(129, 254)));
            if ($urandom_range(0, 3) == 0) drain();   // hold until all results are in
            len = (pairs < 10) ? $urandom_range(1, 4 * pairs + 12) : $urandom_range(1, 4);
            repeat (len) fetch();
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_res);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (o_res.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte exp %h got %h", $time,
                             want.out_byte, o_res.out_byte);
                    errors++;
                end
                if (o_res.last_byte !== want.last_byte) begin
                    $display("%0t: last_byte exp %b got %b", $time,
                             want.last_byte, o_res.last_byte);
                    errors++;
                end
                if (o_res.capture_status !== want.capture_status) begin
                    $display("%0t: capture_status exp %0d got %0d", $time,
                             want.capture_status, o_res.capture_status);
                    errors++;
                end
                if (o_res.edge_count !== want.edge_count) begin
                    $display("%0t: edge_count exp %0d got %0d", $time,
                             want.edge_count, o_res.edge_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_readout();
        test_directed();
        test_overflow();
        test_random();
        drain();
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
